[design/hashed_dedup_append_store_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dedup append store
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HASHED_DEDUP_APPEND_STORE_MACROS_SVH
`define HASHED_DEDUP_APPEND_STORE_MACROS_SVH
`ifndef SYNTHESIS
// Property holds on every cycle out of reset
`define HDS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Antecedent implies consequent on the next cycle
`define HDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HDS_ASSERT(lbl, cond, msg)
`define HDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/hds_pkg.sv]
// ----------------------------------------------------------------------------
// hds_pkg
// Sizes, beat types and status codes of the dedup append store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package hds_pkg;
    localparam int BUF_DEPTH     = 4096;
    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_ARRAY_LEN = 64;

    localparam int LEN_W   = $clog2(BUF_DEPTH + 1);
    localparam int BADDR_W = $clog2(BUF_DEPTH);
    localparam int CNT_W   = $clog2(MAX_ARRAY_LEN + 1);
    localparam int TCNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int TIDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SUM_W   = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

    localparam logic [63:0] HASH_ADD = 64'h517cc1b727220a95;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BUF_FULL   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_TOO_LONG   = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [63:0] value;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [LEN_W-1:0] offset;
        logic             reused;
        t_status          status;
    } t_out;

    // One key table entry: hash and start offset
    typedef struct packed {
        logic [63:0]      key;
        logic [LEN_W-1:0] off;
    } t_entry;
endpackage

[design/hds_ram.sv]
// ----------------------------------------------------------------------------
// hds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

[design/hashed_dedup_append_store.sv]
// ----------------------------------------------------------------------------
// hashed_dedup_append_store
// Hashes arrays element by element, dedups them by hash in a key table and
// appends new arrays to a buffer memory.
// ----------------------------------------------------------------------------
// channel  | ports                  | handshake
// ---------+------------------------+-------------------------------------
// element  | i_start, i_in, o_busy  | beat taken when i_start && !o_busy
// result   | o_strobe, o_out        | one cycle pulse, no backpressure
//
// A non-last element leaves o_busy low; elements are written straight into
// the buffer past its committed length, so no copy pass follows.
// A last element sweeps the filled entries of the key table RAM linearly
// (one read a cycle) up to the first hit; a too-long array skips the
// sweep. Table fill count is cleared by reset; no clearing pass. After a
// sweep, the result strobes for one cycle as o_busy drops.
`timescale 1ns / 1ps
`include "hashed_dedup_append_store_macros.svh"
module hashed_dedup_append_store (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  hds_pkg::t_in i_in,
    output logic         o_busy,
    output logic         o_strobe,
    output hds_pkg::t_out o_out
);
    import hds_pkg::*;

    typedef enum logic {S_IDLE, S_SEARCH} t_state;

    t_state              r_state;
    logic [63:0]         r_hash;
    logic [CNT_W-1:0]    r_count;
    logic                r_too_long;
    logic [LEN_W-1:0]    r_length;
    logic [TCNT_W-1:0]   r_tcount;
    logic [TCNT_W-1:0]   r_rd_idx;
    logic                r_pend;
    logic                r_strobe;
    t_out                r_out;

    logic                acc;
    logic [63:0]         n_hash;
    logic                cnt_full;
    logic [SUM_W-1:0]    fill_sum;
    logic                buf_we;
    logic                hit;
    logic                at_end;
    logic                tbl_re;
    logic                buf_full;
    logic                tbl_full;
    logic                tbl_we;
    t_entry              tbl_rd;
    t_entry              tbl_wd;

    // accept, hash mix and buffer write address
    always_comb begin
        acc      = i_start && (r_state == S_IDLE);
        n_hash   = r_hash ^ (64'(i_in.value) + HASH_ADD + (r_hash << 6) + (r_hash >> 2));
        cnt_full = (r_count == CNT_W'(MAX_ARRAY_LEN));
        fill_sum = SUM_W'(r_length) + SUM_W'(r_count);
        buf_we   = acc && !cnt_full && (fill_sum < SUM_W'(BUF_DEPTH));
    end

    // table sweep decisions
    always_comb begin
        hit      = (r_state == S_SEARCH) && r_pend && (tbl_rd.key == r_hash);
        at_end   = (r_rd_idx == r_tcount);
        tbl_re   = (r_state == S_SEARCH) && !hit && !at_end;
        buf_full = (fill_sum > SUM_W'(BUF_DEPTH));
        tbl_full = (r_tcount == TCNT_W'(TABLE_ENTRIES));
        tbl_we   = (r_state == S_SEARCH) && !hit && at_end && !buf_full && !tbl_full;
        tbl_wd   = '{key: r_hash, off: r_length};
    end

    hds_ram #(.WIDTH(64), .DEPTH(BUF_DEPTH)) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_we),
        .i_wr_addr (fill_sum[BADDR_W-1:0]),
        .i_wr_data (64'(i_in.value)),
        .i_rd_en   (1'b0),
        .i_rd_addr ({BADDR_W{1'b0}}),
        .o_rd_data ()
    );

    hds_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_ENTRIES)) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (r_tcount[TIDX_W-1:0]),
        .i_wr_data (tbl_wd),
        .i_rd_en   (tbl_re),
        .i_rd_addr (r_rd_idx[TIDX_W-1:0]),
        .o_rd_data (tbl_rd)
    );

    // state machine and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hash     <= '0;
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_length   <= '0;
            r_tcount   <= '0;
            r_rd_idx   <= '0;
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_hash <= n_hash;
                        if (!cnt_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_too_long <= 1'b1;
                        end
                        if (i_in.last) begin
                            if (r_too_long || cnt_full) begin
                                r_strobe   <= 1'b1;
                                r_out      <= '{offset: '0, reused: 1'b0, status: ST_TOO_LONG};
                                r_hash     <= '0;
                                r_count    <= '0;
                                r_too_long <= 1'b0;
                            end else begin
                                r_state  <= S_SEARCH;
                                r_rd_idx <= '0;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit || at_end) begin
                        r_strobe   <= 1'b1;
                        r_state    <= S_IDLE;
                        r_hash     <= '0;
                        r_count    <= '0;
                        r_too_long <= 1'b0;
                        if (hit) begin
                            r_out <= '{offset: tbl_rd.off, reused: 1'b1, status: ST_OK};
                        end else if (buf_full) begin
                            r_out <= '{offset: '0, reused: 1'b0, status: ST_BUF_FULL};
                        end else if (tbl_full) begin
                            r_out <= '{offset: '0, reused: 1'b0, status: ST_TABLE_FULL};
                        end else begin
                            r_out    <= '{offset: r_length, reused: 1'b0, status: ST_OK};
                            r_length <= fill_sum[LEN_W-1:0];
                            r_tcount <= r_tcount + TCNT_W'(1);
                        end
                    end else begin
                        r_rd_idx <= r_rd_idx + TCNT_W'(1);
                        r_pend   <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // checks
    `HDS_ASSERT(a_tcount_range, r_tcount <= TCNT_W'(TABLE_ENTRIES), "table count overflow")
    `HDS_ASSERT(a_length_range, r_length <= LEN_W'(BUF_DEPTH), "buffer length overflow")
    `HDS_ASSERT_NEXT(a_strobe_src, !(o_busy || (i_start && i_in.last)), !o_strobe, "spurious result")
    `HDS_ASSERT_NEXT(a_insert_len, tbl_we, r_length == $past(fill_sum[LEN_W-1:0]), "length not advanced")
endmodule

[bench/tb_hashed_dedup_append_store.sv]
// ----------------------------------------------------------------------------
// tb_hashed_dedup_append_store
// Sends arrays of 64-bit elements to the dedup store and checks each result
// beat against a predictor of the running hash, the key table and the
// buffer fill. The traffic is directed extremes first, then random new,
// repeated and overlong arrays, closing with a stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_hashed_dedup_append_store;
    import hds_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    // Predicts dedup results and holds the ones still to come
    class dedup_scoreboard;
        logic [63:0]      hash_acc;
        int               elem_count;
        bit               overlong;
        int               fill_len;
        logic [63:0]      keys [TABLE_ENTRIES];
        logic [LEN_W-1:0] starts [TABLE_ENTRIES];
        bit               used [TABLE_ENTRIES];
        t_out             pending_q [$];
        int               mismatches;

        function new();
            hash_acc   = '0;
            elem_count = 0;
            overlong   = 0;
            fill_len   = 0;
            mismatches = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        // Accepted element beat: update hash, predict result on last
        function void note_beat(t_in beat);
            t_out res;
            int   slot;
            bit   hit;
            logic [63:0] v;
            v = beat.value;
            hash_acc = hash_acc ^ (v + HASH_ADD + (hash_acc << 6) + (hash_acc >> 2));
            if (elem_count < MAX_ARRAY_LEN) elem_count++;
            else overlong = 1;
            if (!beat.last) return;
            res  = '{offset: '0, reused: 1'b0, status: ST_OK};
            slot = -1;
            hit  = 0;
            if (overlong) begin
                res.status = ST_TOO_LONG;
            end else begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (used[i]) begin
                        if (!hit && keys[i] == hash_acc) begin
                            hit = 1;
                            res.offset = starts[i];
                            res.reused = 1'b1;
                        end
                    end else if (slot < 0) begin
                        slot = i;
                    end
                end
                if (!hit) begin
                    if (fill_len + elem_count > BUF_DEPTH) begin
                        res.status = ST_BUF_FULL;
                    end else if (slot < 0) begin
                        res.status = ST_TABLE_FULL;
                    end else begin
                        keys[slot]   = hash_acc;
                        starts[slot] = LEN_W'(fill_len);
                        used[slot]   = 1;
                        res.offset   = LEN_W'(fill_len);
                        fill_len     += elem_count;
                    end
                end
            end
            pending_q.push_back(res);
            hash_acc   = '0;
            elem_count = 0;
            overlong   = 0;
        endfunction

        // Result beat against the oldest prediction
        function void check_result(t_out got);
            t_out exp;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: offset=%0d reused=%0b status=%0d",
                             got.offset, got.reused, got.status);
                return;
            end
            exp = pending_q.pop_front();
            if (got.offset !== exp.offset || got.reused !== exp.reused ||
                got.status !== exp.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp offset=%0d reused=%0b status=%0d,",
                              " got offset=%0d reused=%0b status=%0d"},
                             exp.offset, exp.reused, exp.status,
                             got.offset, got.reused, got.status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_in;
    logic o_busy;
    logic o_strobe;
    t_out o_out;

    dedup_scoreboard sb;
    bit          idle_on;
    int          beats_sent;
    int          quiet_cycles;
    logic [63:0] hist_base [$];
    int          hist_len [$];

    hashed_dedup_append_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Beat monitor, result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_beat(i_in);
            if (o_strobe) sb.check_result(o_out);
            if ((i_start && !o_busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_hashed_dedup_append_store: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Element i of an array is derived from its base so it can be replayed
    function automatic logic [63:0] elem_of(logic [63:0] base, int idx);
        return base ^ ({32'h9e3779b9, 32'h7f4a7c15} * idx) ^ (64'(idx) << 17);
    endfunction

    // One element beat; start stays high across back-to-back beats
    task automatic send_beat(logic [63:0] v, bit last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= '{value: v, last: last};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_array(logic [63:0] base, int len);
        for (int i = 0; i < len; i++) send_beat(elem_of(base, i), i == len - 1);
    endtask

    task automatic send_single(logic [63:0] v);
        send_beat(v, 1'b1);
    endtask

    // Random array: new content, replay of an old one, or overlong
    task automatic send_random_array();
        int          pick;
        int          len;
        int          k;
        logic [63:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 25 && hist_base.size() > 0) begin
            k = $urandom_range(0, hist_base.size() - 1);
            send_array(hist_base[k], hist_len[k]);
        end else begin
            base = {$urandom, $urandom};
            if (pick < 30) len = $urandom_range(MAX_ARRAY_LEN + 1, MAX_ARRAY_LEN + 8);
            else if (pick < 45) len = $urandom_range(33, MAX_ARRAY_LEN);
            else len = $urandom_range(1, 32);
            hist_base.push_back(base);
            hist_len.push_back(len);
            send_array(base, len);
        end
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_in         = '0;
        idle_on      = 1'b1;
        beats_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: value extremes, a hit, full-length and overlong arrays
        send_single(64'h8000_0000_0000_0000);
        send_single(64'h7fff_ffff_ffff_ffff);
        send_single(64'h0);
        send_single(64'hffff_ffff_ffff_ffff);
        send_single(64'h0);
        send_array(64'h0123_4567_89ab_cdef, MAX_ARRAY_LEN);
        send_array(64'h0123_4567_89ab_cdef, MAX_ARRAY_LEN);
        send_array(64'hfedc_ba98_7654_3210, MAX_ARRAY_LEN + 1);
        send_single(64'h7fff_ffff_ffff_ffff);

        // Random traffic with idle bursts
        while (beats_sent < 1000) send_random_array();

        // Closing stretch at full rate
        idle_on = 1'b0;
        while (beats_sent < 1200) send_random_array();
        i_start <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_hashed_dedup_append_store: PASS");
        end else begin
            $display("tb_hashed_dedup_append_store: FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/hds_pkg.sv
design/hds_ram.sv
design/hashed_dedup_append_store.sv
bench/tb_hashed_dedup_append_store.sv
